### hw/rtl/djet_pkg.sv
// ----------------------------------------------------------------------------
// djet_pkg
// Shared widths, register map, configuration and control types for the
// depth to jet colormap block.
// ----------------------------------------------------------------------------
package djet_pkg;

    localparam int DEPTH_W       = 16;
    localparam int BYTE_W        = 8;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DIV_STEPS     = 4;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;

    typedef enum logic {
        REG_WIN_LOW  = 1'b0,
        REG_WIN_HIGH = 1'b1
    } t_reg_idx;

    localparam logic [DEPTH_W-1:0] WIN_LOW_RST  = '0;
    localparam logic [DEPTH_W-1:0] WIN_HIGH_RST = '1;

    typedef struct packed {
        logic [DEPTH_W-1:0] low;
        logic [DEPTH_W-1:0] high;
    } t_window;

    typedef struct packed {
        logic vld;
        logic neg;
        logic sat;
        logic win_ok;
    } t_ctl;

endpackage

### hw/rtl/djet_in_if.sv
// ----------------------------------------------------------------------------
// djet_in_if
// Depth sample channel: valid, ready and one depth item.
// ----------------------------------------------------------------------------
interface djet_in_if;
    logic                        valid;
    logic                        ready;
    logic [djet_pkg::DEPTH_W-1:0] depth_sample;

    modport source (output valid, output depth_sample, input ready);
    modport sink   (input valid, input depth_sample, output ready);
endinterface

### hw/rtl/djet_out_if.sv
// ----------------------------------------------------------------------------
// djet_out_if
// Color pixel channel: valid, ready and one jet color item.
// ----------------------------------------------------------------------------
interface djet_out_if;
    logic                       valid;
    logic                       ready;
    logic [djet_pkg::BYTE_W-1:0] blue_byte;
    logic [djet_pkg::BYTE_W-1:0] green_byte;
    logic [djet_pkg::BYTE_W-1:0] red_byte;

    modport source (output valid, output blue_byte, output green_byte, output red_byte,
                    input ready);
    modport sink   (input valid, input blue_byte, input green_byte, input red_byte,
                    output ready);
endinterface

### hw/rtl/djet_cfg.sv
// ----------------------------------------------------------------------------
// djet_cfg
// APB register file holding the depth window bounds.
// ----------------------------------------------------------------------------
module djet_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [djet_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [djet_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [djet_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output djet_pkg::t_window                   o_window
);

    logic [djet_pkg::DEPTH_W-1:0] r_low;
    logic [djet_pkg::DEPTH_W-1:0] r_high;
    logic                         w_wr;
    djet_pkg::t_reg_idx           w_idx;

    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = djet_pkg::t_reg_idx'(paddr[2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= djet_pkg::WIN_LOW_RST;
            r_high <= djet_pkg::WIN_HIGH_RST;
        end else if (w_wr) begin
            case (w_idx)
                djet_pkg::REG_WIN_LOW:  r_low  <= pwdata[djet_pkg::DEPTH_W-1:0];
                djet_pkg::REG_WIN_HIGH: r_high <= pwdata[djet_pkg::DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            djet_pkg::REG_WIN_LOW:  prdata = djet_pkg::APB_DATA_W'(r_low);
            djet_pkg::REG_WIN_HIGH: prdata = djet_pkg::APB_DATA_W'(r_high);
            default:                prdata = '0;
        endcase
    end

    assign o_window.low  = r_low;
    assign o_window.high = r_high;

endmodule

### hw/rtl/djet_front.sv
// ----------------------------------------------------------------------------
// djet_front
// Entry stage: offset from the window start, its magnitude and sign, the
// window span, the saturation flag and the window-valid flag.
// ----------------------------------------------------------------------------
module djet_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [djet_pkg::DEPTH_W-1:0]  i_depth,
    input  djet_pkg::t_window             i_window,
    output djet_pkg::t_ctl                o_ctl,
    output logic [djet_pkg::DEPTH_W-1:0]  o_mag,
    output logic [djet_pkg::DEPTH_W-1:0]  o_den
);

    localparam int DW = djet_pkg::DEPTH_W;

    logic [DW:0]    w_up;
    logic [DW:0]    w_dn;
    logic [DW:0]    w_span;
    logic [DW-1:0]  n_mag;
    djet_pkg::t_ctl n_ctl;

    djet_pkg::t_ctl r_ctl;
    logic [DW-1:0]  r_mag;
    logic [DW-1:0]  r_den;

    always_comb begin
        w_up          = {1'b0, i_depth} - {1'b0, i_window.low};
        w_dn          = {1'b0, i_window.low} - {1'b0, i_depth};
        w_span        = {1'b0, i_window.high} - {1'b0, i_window.low};
        n_mag         = w_up[DW] ? w_dn[DW-1:0] : w_up[DW-1:0];
        n_ctl.vld     = i_valid;
        n_ctl.neg     = w_up[DW];
        n_ctl.win_ok  = !w_span[DW] && (w_span != '0);
        n_ctl.sat     = {1'b0, n_mag} >= {w_span[DW-1:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= n_mag;
            r_den <= w_span[DW-1:0];
        end
    end

    assign o_ctl = r_ctl;
    assign o_mag = r_mag;
    assign o_den = r_den;

endmodule

### hw/rtl/djet_div.sv
// ----------------------------------------------------------------------------
// djet_div
// Pipelined restoring divider: magnitude * 2^(FRAC_BITS+2) / span, four
// quotient bits per stage, with a sticky flag for a nonzero remainder.
// ----------------------------------------------------------------------------
module djet_div #(
    parameter int FRAC_BITS = djet_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  djet_pkg::t_ctl                  i_ctl,
    input  logic [djet_pkg::DEPTH_W-1:0]    i_mag,
    input  logic [djet_pkg::DEPTH_W-1:0]    i_den,
    output djet_pkg::t_ctl                  o_ctl,
    output logic [FRAC_BITS+2:0]            o_quo,
    output logic                            o_rem_nz
);

    localparam int DW    = djet_pkg::DEPTH_W;
    localparam int SPS   = djet_pkg::DIV_STEPS;
    localparam int QW    = FRAC_BITS + 3;
    localparam int NSTG  = (QW + SPS - 1) / SPS;
    localparam int REM_W = DW + 1;

    djet_pkg::t_ctl  w_ctl [NSTG+1];
    logic [DW-1:0]   w_rem [NSTG+1];
    logic [DW-1:0]   w_den [NSTG+1];
    logic [QW-1:0]   w_quo [NSTG+1];

    assign w_ctl[0] = i_ctl;
    assign w_rem[0] = i_mag;
    assign w_den[0] = i_den;
    assign w_quo[0] = '0;

    for (genvar s = 0; s < NSTG; s++) begin : g_stage
        djet_pkg::t_ctl r_ctl;
        logic [DW-1:0]  r_rem;
        logic [DW-1:0]  r_den;
        logic [QW-1:0]  r_quo;
        logic [DW-1:0]  n_rem;
        logic [QW-1:0]  n_quo;

        always_comb begin
            logic [REM_W-1:0] v_dbl;
            logic [DW-1:0]    v_rem;
            logic [QW-1:0]    v_quo;
            logic             v_bit;
            v_dbl = '0;
            v_bit = 1'b0;
            v_rem = w_rem[s];
            v_quo = w_quo[s];
            for (int j = 0; j < SPS; j++) begin
                if (s * SPS + j < QW) begin
                    if (s * SPS + j == 0) begin
                        v_dbl = {1'b0, v_rem};
                    end else begin
                        v_dbl = {v_rem, 1'b0};
                    end
                    v_bit = v_dbl >= {1'b0, w_den[s]};
                    if (v_bit) begin
                        v_dbl = v_dbl - {1'b0, w_den[s]};
                    end
                    v_rem = v_dbl[DW-1:0];
                    v_quo = {v_quo[QW-2:0], v_bit};
                end
            end
            n_rem = v_rem;
            n_quo = v_quo;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl <= '0;
            end else if (i_en) begin
                r_ctl <= w_ctl[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= n_rem;
                r_den <= w_den[s];
                r_quo <= n_quo;
            end
        end

        assign w_ctl[s+1] = r_ctl;
        assign w_rem[s+1] = r_rem;
        assign w_den[s+1] = r_den;
        assign w_quo[s+1] = r_quo;
    end

    assign o_ctl    = w_ctl[NSTG];
    assign o_quo    = w_quo[NSTG];
    assign o_rem_nz = |w_rem[NSTG];

endmodule

### hw/rtl/djet_ramp.sv
// ----------------------------------------------------------------------------
// djet_ramp
// Back end: signed position, three clamped jet ramps, scale to bytes.
// Three register stages; the last one is the output register.
// ----------------------------------------------------------------------------
module djet_ramp #(
    parameter int FRAC_BITS = djet_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  djet_pkg::t_ctl                i_ctl,
    input  logic [FRAC_BITS+2:0]          i_quo,
    input  logic                          i_rem_nz,
    output logic                          o_vld,
    output logic [djet_pkg::BYTE_W-1:0]   o_blue,
    output logic [djet_pkg::BYTE_W-1:0]   o_green,
    output logic [djet_pkg::BYTE_W-1:0]   o_red
);

    localparam int BW   = djet_pkg::BYTE_W;
    localparam int QW   = FRAC_BITS + 3;
    localparam int TW   = FRAC_BITS + 5;
    localparam int CW   = FRAC_BITS + 1;
    localparam int PW   = CW + BW;
    localparam int HALF = 2 ** (FRAC_BITS - 1);

    localparam logic signed [TW-1:0] T_ONE   = TW'(2 * HALF);
    localparam logic [TW-1:0]        T_SAT   = TW'(16 * HALF);
    localparam logic signed [TW-1:0] K_HALF  = TW'(HALF);
    localparam logic signed [TW-1:0] K_1P5   = TW'(3 * HALF);
    localparam logic signed [TW-1:0] K_2P5   = TW'(5 * HALF);
    localparam logic signed [TW-1:0] K_3P5   = TW'(7 * HALF);
    localparam logic signed [TW-1:0] K_4P5   = TW'(9 * HALF);

    function automatic logic [CW-1:0] ramp_clamp(input logic signed [TW-1:0] rise,
                                                 input logic signed [TW-1:0] fall);
        logic signed [TW-1:0] v_min;
        v_min = (rise < fall) ? rise : fall;
        if (v_min < 0) begin
            return '0;
        end else if (v_min > T_ONE) begin
            return T_ONE[CW-1:0];
        end
        return v_min[CW-1:0];
    endfunction

    function automatic logic [BW-1:0] to_byte(input logic [CW-1:0] c);
        logic [PW-1:0] v_prod;
        v_prod = {c, {BW{1'b0}}} - {{BW{1'b0}}, c};
        return v_prod[FRAC_BITS+BW-1:FRAC_BITS];
    endfunction

    // position stage
    djet_pkg::t_ctl        r_t_ctl;
    logic signed [TW-1:0]  r_t;
    logic signed [TW-1:0]  n_t;

    always_comb begin
        logic [TW-1:0] v_mag;
        if (i_ctl.sat) begin
            v_mag = T_SAT;
        end else begin
            v_mag = {{(TW-QW){1'b0}}, i_quo} + TW'(i_ctl.neg && i_rem_nz);
        end
        n_t = i_ctl.neg ? -$signed(v_mag) : $signed(v_mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_ctl <= '0;
        end else if (i_en) begin
            r_t_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t <= n_t;
        end
    end

    // ramp stage
    logic           r_c_vld;
    logic [CW-1:0]  r_c_blue;
    logic [CW-1:0]  r_c_green;
    logic [CW-1:0]  r_c_red;
    logic [CW-1:0]  n_c_blue;
    logic [CW-1:0]  n_c_green;
    logic [CW-1:0]  n_c_red;

    always_comb begin
        if (r_t_ctl.win_ok) begin
            n_c_blue  = ramp_clamp(r_t + K_HALF, K_2P5 - r_t);
            n_c_green = ramp_clamp(r_t - K_HALF, K_3P5 - r_t);
            n_c_red   = ramp_clamp(r_t - K_1P5,  K_4P5 - r_t);
        end else begin
            n_c_blue  = '0;
            n_c_green = '0;
            n_c_red   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_c_vld <= r_t_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_blue  <= n_c_blue;
            r_c_green <= n_c_green;
            r_c_red   <= n_c_red;
        end
    end

    // byte stage, holds the result until taken
    logic           r_b_vld;
    logic [BW-1:0]  r_b_blue;
    logic [BW-1:0]  r_b_green;
    logic [BW-1:0]  r_b_red;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_b_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_blue  <= to_byte(r_c_blue);
            r_b_green <= to_byte(r_c_green);
            r_b_red   <= to_byte(r_c_red);
        end
    end

    assign o_vld   = r_b_vld;
    assign o_blue  = r_b_blue;
    assign o_green = r_b_green;
    assign o_red   = r_b_red;

endmodule

### hw/rtl/depth_to_jet_colormap_top.sv
// An accepted item passes the entry stage, the divider stages and the back-end stages in order.
// Throughput: one item per cycle; the pipeline advances whenever the output register is
// empty or its item is taken, and holds as one otherwise.
// Depth of the pipeline is set by the divider, four quotient bits per stage.
// Reset (synchronous, active low) clears all stage valid bits and loads the window
// registers with low = 0, high = 65535.
// ----------------------------------------------------------------------------
// depth_to_jet_colormap_top
// Jet false-color mapping of 16-bit depth samples over a configured window.
// ----------------------------------------------------------------------------
module depth_to_jet_colormap_top #(
    parameter int FRAC_BITS = djet_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    djet_in_if.sink                         i_depth,
    djet_out_if.source                      o_pix,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [djet_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [djet_pkg::APB_DATA_W-1:0] pwdata,
    output logic [djet_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int DW = djet_pkg::DEPTH_W;

    logic              w_en;
    djet_pkg::t_window w_window;
    djet_pkg::t_ctl    w_front_ctl;
    logic [DW-1:0]     w_mag;
    logic [DW-1:0]     w_den;
    djet_pkg::t_ctl    w_div_ctl;
    logic [FRAC_BITS+2:0] w_quo;
    logic              w_rem_nz;

    assign w_en          = !o_pix.valid || o_pix.ready;
    assign i_depth.ready = w_en;

    djet_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_window (w_window)
    );

    djet_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_depth.valid),
        .i_depth  (i_depth.depth_sample),
        .i_window (w_window),
        .o_ctl    (w_front_ctl),
        .o_mag    (w_mag),
        .o_den    (w_den)
    );

    djet_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_ctl    (w_front_ctl),
        .i_mag    (w_mag),
        .i_den    (w_den),
        .o_ctl    (w_div_ctl),
        .o_quo    (w_quo),
        .o_rem_nz (w_rem_nz)
    );

    djet_ramp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ramp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_ctl    (w_div_ctl),
        .i_quo    (w_quo),
        .i_rem_nz (w_rem_nz),
        .o_vld    (o_pix.valid),
        .o_blue   (o_pix.blue_byte),
        .o_green  (o_pix.green_byte),
        .o_red    (o_pix.red_byte)
    );

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pix.valid)
        else $error("result valid right after reset");

    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid && !o_pix.ready |-> !i_depth.ready)
        else $error("item taken while result stalled");

    a_no_red_blue_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid |-> !(o_pix.blue_byte == '1 && o_pix.red_byte == '1))
        else $error("red and blue both at full scale");

endmodule
